@@ rtl/drr_pkg.sv @@
// Package with the shared constants, types and slot search function of the picker.
`timescale 1ns / 1ps
package drr_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int FRAC_BITS = 8;

    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(2 * NUM_SLOTS + 1);
    localparam int WEIGHT_W  = 16;
    localparam int QUANT_W   = WEIGHT_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CHOSEN_W  = 3;

    localparam logic [QUANT_W-1:0] ONE_FIXED = QUANT_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_PROBE
    } t_state;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][WEIGHT_W-1:0] weight;
        logic [NUM_SLOTS-1:0]               present;
        logic [CNT_W-1:0]                   probes;
    } t_slot_info;

    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  addr;
        logic [QUANT_W-1:0] data;
    } t_qwr;

    function automatic logic [SLOT_W-1:0] next_present(input logic [NUM_SLOTS-1:0] mask,
                                                       input logic [SLOT_W-1:0] from);
        logic [SLOT_W:0]   idx;
        logic [SLOT_W-1:0] res;
        logic              hit;
        res = '0;
        hit = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            idx = {1'b0, from} + (SLOT_W + 1)'(k);
            if (idx >= (SLOT_W + 1)'(NUM_SLOTS)) begin
                idx = idx - (SLOT_W + 1)'(NUM_SLOTS);
            end
            if (!hit && mask[idx[SLOT_W-1:0]]) begin
                res = idx[SLOT_W-1:0];
                hit = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/drr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module drr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/drr_weights.sv @@
// Weight register file with presence mask, probe budget and quantum writes when a slot is added or cleared.
`timescale 1ns / 1ps
module drr_weights (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [drr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drr_pkg::WEIGHT_W-1:0]   i_cfg_data,
    output drr_pkg::t_slot_info            o_info,
    output drr_pkg::t_qwr                  o_qwr
);
    import drr_pkg::*;

    logic [NUM_SLOTS-1:0][WEIGHT_W-1:0] r_weight;
    logic [NUM_SLOTS-1:0]               present;
    logic [CNT_W-1:0]                   count;
    logic                               idx_ok;
    logic [SLOT_W-1:0]                  sel;

    assign idx_ok = ({1'b0, i_cfg_index} < (CFG_IDX_W + 1)'(NUM_SLOTS));
    assign sel    = i_cfg_index[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_cfg_wr_en && idx_ok) begin
            r_weight[sel] <= i_cfg_data;
        end
    end

    always_comb begin
        count = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            present[s] = (r_weight[s] != '0);
            count      = count + CNT_W'(present[s]);
        end
    end

    always_comb begin
        o_info.weight  = r_weight;
        o_info.present = present;
        o_info.probes  = count << 1;
        o_qwr.en   = i_cfg_wr_en && idx_ok && ((i_cfg_data == '0) || (r_weight[sel] == '0));
        o_qwr.addr = sel;
        o_qwr.data = QUANT_W'(i_cfg_data);
    end

endmodule

@@ rtl/drr_engine.sv @@
// Pick sequencer that probes slot quanta in memory, one probe per cycle.
`timescale 1ns / 1ps
module drr_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_pick_request,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [drr_pkg::CHOSEN_W-1:0]  o_chosen_slot,
    output logic                          o_found,
    input  drr_pkg::t_slot_info           i_info,
    output logic [drr_pkg::SLOT_W-1:0]    o_rd_addr,
    input  logic [drr_pkg::QUANT_W-1:0]   i_rd_data,
    output drr_pkg::t_qwr                 o_qwr
);
    import drr_pkg::*;

    t_state               r_state, n_state;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [SLOT_W-1:0]    r_ptr, n_ptr;
    logic [CNT_W-1:0]     r_left, n_left;
    logic                 r_fwd, n_fwd;
    logic [QUANT_W-1:0]   r_fwd_data, n_fwd_data;
    logic                 r_out_valid, n_out_valid;
    logic [CHOSEN_W-1:0]  r_out_chosen, n_out_chosen;
    logic                 r_out_found, n_out_found;

    logic                 accept;
    logic                 start_pick;
    logic [QUANT_W-1:0]   quantum;
    logic                 hit;
    logic                 last;
    logic [QUANT_W-1:0]   wr_val;
    logic [SLOT_W-1:0]    slot_inc;
    logic [SLOT_W-1:0]    s_next;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign start_pick = i_pick_request && (i_info.present != '0);
    assign quantum    = r_fwd ? r_fwd_data : i_rd_data;
    assign hit        = (quantum >= ONE_FIXED);
    assign last       = (r_left == CNT_W'(1));
    assign wr_val     = hit ? (quantum - ONE_FIXED)
                            : (quantum + QUANT_W'(i_info.weight[r_slot]));
    assign slot_inc   = (r_slot == SLOT_W'(NUM_SLOTS - 1)) ? '0 : (r_slot + SLOT_W'(1));
    assign s_next     = next_present(i_info.present, slot_inc);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && start_pick) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = ST_PROBE;
            end
            ST_PROBE: begin
                if (hit || last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_slot       = r_slot;
        n_ptr        = r_ptr;
        n_left       = r_left;
        n_fwd        = r_fwd;
        n_fwd_data   = r_fwd_data;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_chosen = r_out_chosen;
        n_out_found  = r_out_found;
        o_rd_addr    = r_slot;
        o_qwr.en     = 1'b0;
        o_qwr.addr   = r_slot;
        o_qwr.data   = wr_val;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (start_pick) begin
                        n_slot = next_present(i_info.present, r_ptr);
                        n_left = i_info.probes;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_chosen = '0;
                        n_out_found  = 1'b0;
                    end
                end
            end
            ST_START: begin
                n_fwd = 1'b0;
            end
            ST_PROBE: begin
                o_qwr.en = 1'b1;
                if (hit) begin
                    n_ptr        = r_slot;
                    n_out_valid  = 1'b1;
                    n_out_chosen = CHOSEN_W'(r_slot);
                    n_out_found  = 1'b1;
                end else begin
                    n_ptr = s_next;
                    if (last) begin
                        n_out_valid  = 1'b1;
                        n_out_chosen = '0;
                        n_out_found  = 1'b0;
                    end else begin
                        o_rd_addr  = s_next;
                        n_slot     = s_next;
                        n_left     = r_left - CNT_W'(1);
                        n_fwd      = (s_next == r_slot);
                        n_fwd_data = wr_val;
                    end
                end
            end
            default: begin
                n_fwd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_left      <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_left      <= n_left;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_fwd_data   <= n_fwd_data;
        r_out_chosen <= n_out_chosen;
        r_out_found  <= n_out_found;
    end

    assign o_out_valid   = r_out_valid;
    assign o_chosen_slot = r_out_chosen;
    assign o_found       = r_out_found;

    a_budget_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (r_left != '0))
        else $error("probe started with no budget left");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> !r_out_valid)
        else $error("result register busy while probing");

    a_probe_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> i_info.present[r_slot])
        else $error("probing an absent slot");

    a_ptr_on_choice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (CHOSEN_W'(r_ptr) == r_out_chosen))
        else $error("pointer does not rest on the chosen slot");

endmodule

@@ rtl/deficit_round_robin_picker_core.sv @@
// Top level of the deficit round robin slot picker.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------
//  in       | i_in_valid / o_in_ready        | i_pick_request
//  out      | o_out_valid / i_out_ready      | o_chosen_slot, o_found
//  cfg      | i_cfg_wr_en                    | i_cfg_index, i_cfg_data
//
// A pick beat goes from acceptance through the start state and P probes to its result,
// where P is the number of probes, at most twice the present slots.
// A beat without a pick, or with no slot present, has its result in the next cycle.
// Probes run one per cycle through the read port of the quantum memory.
// Reset is synchronous and clears weights, pointer and control; no clearing pass.
// A stalled result holds the output register and the input side stays not ready.
`timescale 1ns / 1ps
module deficit_round_robin_picker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_pick_request,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [drr_pkg::CHOSEN_W-1:0]  o_chosen_slot,
    output logic                          o_found,
    input  logic                          i_cfg_wr_en,
    input  logic [drr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drr_pkg::WEIGHT_W-1:0]  i_cfg_data
);
    import drr_pkg::*;

    t_slot_info          info;
    t_qwr                cfg_qwr;
    t_qwr                eng_qwr;
    t_qwr                ram_qwr;
    logic [SLOT_W-1:0]   rd_addr;
    logic [QUANT_W-1:0]  rd_data;

    drr_weights u_weights (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_info      (info),
        .o_qwr       (cfg_qwr)
    );

    assign ram_qwr = eng_qwr.en ? eng_qwr : cfg_qwr;

    drr_ram #(
        .WIDTH (QUANT_W),
        .DEPTH (NUM_SLOTS)
    ) u_quantum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_qwr.en),
        .i_wr_addr (ram_qwr.addr),
        .i_wr_data (ram_qwr.data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    drr_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pick_request (i_pick_request),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_chosen_slot  (o_chosen_slot),
        .o_found        (o_found),
        .i_info         (info),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_qwr          (eng_qwr)
    );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the deficit round robin slot picker.
`timescale 1ns / 1ps
module testbench;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 24;
    localparam int PHASES       = 24;
    localparam int PHASE_BEATS  = 76;
    localparam int DIR_ROWS     = 42;

    typedef enum logic {
        ROW_CFG,
        ROW_PICK
    } t_row_kind;

    typedef struct packed {
        logic                   found;
        logic [drr_pkg::CHOSEN_W-1:0] slot;
    } t_pick_result;

    typedef struct packed {
        t_row_kind                    kind;
        logic                         req;
        logic [drr_pkg::CFG_IDX_W-1:0] idx;
        logic [drr_pkg::WEIGHT_W-1:0] data;
        logic                         typed;
        logic                         found;
        logic [drr_pkg::CHOSEN_W-1:0] slot;
    } t_dir_row;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_ready;
    logic                          i_pick_request = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready    = 1'b0;
    logic [drr_pkg::CHOSEN_W-1:0]  o_chosen_slot;
    logic                          o_found;
    logic                          i_cfg_wr_en    = 1'b0;
    logic [drr_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [drr_pkg::WEIGHT_W-1:0]  i_cfg_data     = '0;

    logic [drr_pkg::WEIGHT_W-1:0] slot_weight [drr_pkg::NUM_SLOTS];
    logic [drr_pkg::QUANT_W-1:0]  slot_quant  [drr_pkg::NUM_SLOTS];
    logic [drr_pkg::SLOT_W-1:0]   rr_ptr;

    t_pick_result pending_picks [$];
    t_pick_result head_pick;
    t_dir_row     dir_table [DIR_ROWS];

    int  tx_idle_pct     = 0;
    int  rx_stall_pct    = 0;
    bit  hold_off_req    = 1'b0;
    int  fail_cnt        = 0;
    int  beats_sent      = 0;
    int  granted_cnt     = 0;
    int  denied_cnt      = 0;
    int  weight_loads    = 0;
    int  quiet_cycles    = 0;

    deficit_round_robin_picker_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pick_request (i_pick_request),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_chosen_slot  (o_chosen_slot),
        .o_found        (o_found),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    function automatic logic [drr_pkg::SLOT_W-1:0] first_present_from(
        input logic [drr_pkg::SLOT_W-1:0] start);
        logic [drr_pkg::SLOT_W-1:0] cand;
        logic [drr_pkg::SLOT_W-1:0] hit;
        logic                       got;
        hit = start;
        got = 1'b0;
        for (int k = 0; k < drr_pkg::NUM_SLOTS; k++) begin
            cand = start + drr_pkg::SLOT_W'(k);
            if (!got && slot_weight[cand] != '0) begin
                hit = cand;
                got = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void set_slot_weight(input logic [drr_pkg::SLOT_W-1:0] s,
                                            input logic [drr_pkg::WEIGHT_W-1:0] w);
        if (w == '0) begin
            slot_quant[s] = '0;
        end else if (slot_weight[s] == '0) begin
            slot_quant[s] = {1'b0, w};
        end
        slot_weight[s] = w;
    endfunction

    function automatic t_pick_result predict_pick(input logic req);
        t_pick_result               res;
        int                         present_cnt;
        logic [drr_pkg::SLOT_W-1:0] pos;
        logic [drr_pkg::SLOT_W-1:0] s;
        res = '0;
        present_cnt = 0;
        for (int k = 0; k < drr_pkg::NUM_SLOTS; k++) begin
            if (slot_weight[k] != '0) begin
                present_cnt++;
            end
        end
        if (req && present_cnt != 0) begin
            pos = rr_ptr;
            for (int n = 0; n < 2 * present_cnt && !res.found; n++) begin
                s = first_present_from(pos);
                if (slot_quant[s] >= drr_pkg::ONE_FIXED) begin
                    slot_quant[s] = slot_quant[s] - drr_pkg::ONE_FIXED;
                    rr_ptr = s;
                    res.found = 1'b1;
                    res.slot = s;
                end else begin
                    slot_quant[s] = slot_quant[s] + {1'b0, slot_weight[s]};
                    pos = first_present_from(s + 1'b1);
                    rr_ptr = pos;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [drr_pkg::WEIGHT_W-1:0] random_weight();
        case ($urandom_range(9))
            0, 1: return '0;
            2: return 16'hFFFF;
            3: return 16'h0001;
            4, 5: return 16'($urandom_range(1, 255));
            6, 7: return 16'($urandom_range(64, 768));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic load_weights(input logic [7:0][drr_pkg::WEIGHT_W-1:0] w,
                                input logic [7:0] mask);
        i_in_valid <= 1'b0;
        while (pending_picks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        for (int s = 0; s < drr_pkg::NUM_SLOTS; s++) begin
            if (mask[s]) begin
                i_cfg_wr_en <= 1'b1;
                i_cfg_index <= drr_pkg::CFG_IDX_W'(s);
                i_cfg_data  <= w[s];
                @(posedge i_clk);
                set_slot_weight(drr_pkg::SLOT_W'(s), w[s]);
            end
        end
        i_cfg_wr_en <= 1'b0;
        weight_loads++;
    endtask

    task automatic send_pick(input logic req, input logic typed, input t_pick_result typed_res);
        t_pick_result model_res;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pick_request <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        model_res = predict_pick(req);
        pending_picks.insert(pending_picks.size(), typed ? typed_res : model_res);
        beats_sent++;
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_picks.size() == 0) begin
                $error("unexpected result beat: found %0d, chosen_slot %0d",
                       o_found, o_chosen_slot);
                fail_cnt++;
            end else begin
                head_pick = pending_picks.pop_front();
                if (o_found !== head_pick.found) begin
                    $error("found: expected %0d, actual %0d", head_pick.found, o_found);
                    fail_cnt++;
                end
                if (o_chosen_slot !== head_pick.slot) begin
                    $error("chosen_slot: expected %0d, actual %0d",
                           head_pick.slot, o_chosen_slot);
                    fail_cnt++;
                end
                if (o_found === 1'b1) begin
                    granted_cnt++;
                end else begin
                    denied_cnt++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $error("no beat moved for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [7:0][drr_pkg::WEIGHT_W-1:0] phase_w;
        logic [7:0]                        phase_mask;
        t_pick_result                      typed_res;
        int                                mode;

        for (int s = 0; s < drr_pkg::NUM_SLOTS; s++) begin
            slot_weight[s] = '0;
            slot_quant[s]  = '0;
        end
        rr_ptr = '0;

        // kind, pick, index, weight, typed, found, slot
        dir_table = '{
            '{ROW_PICK, 1'b0, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd7, 16'hFFFF, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b1, 1'b1, 3'd7},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b1, 1'b1, 3'd7},
            '{ROW_CFG,  1'b0, 3'd7, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd0, 16'h0001, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd0, 16'h0100, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd3, 16'h0080, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd5, 16'h0180, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b0, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd5, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd1, 16'h0001, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd2, 16'h0001, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd4, 16'h0001, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd5, 16'h0001, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd6, 16'h0001, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd7, 16'h0001, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd0, 16'h0001, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd3, 16'h0001, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd0, 16'hFFFF, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd1, 16'hFFFF, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd2, 16'hFFFF, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd3, 16'hFFFF, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd4, 16'hFFFF, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd5, 16'hFFFF, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd6, 16'hFFFF, 1'b0, 1'b0, 3'd0},
            '{ROW_CFG,  1'b0, 3'd7, 16'hFFFF, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b1, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
            '{ROW_PICK, 1'b0, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_CFG) begin
                phase_w = '0;
                phase_w[dir_table[r].idx] = dir_table[r].data;
                load_weights(phase_w, 8'(1) << dir_table[r].idx);
            end else begin
                typed_res = {dir_table[r].found, dir_table[r].slot};
                send_pick(dir_table[r].req, dir_table[r].typed, typed_res);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            mode = ph / (PHASES / 4);
            for (int s = 0; s < drr_pkg::NUM_SLOTS; s++) begin
                phase_w[s] = random_weight();
            end
            phase_mask = (ph == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            load_weights(phase_w, phase_mask);
            tx_idle_pct  = (mode == 1) ? 60 : (mode == 3) ? 20 : 0;
            rx_stall_pct = (mode == 2) ? 60 : (mode == 3) ? 20 : 0;
            if (ph == 0) begin
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                send_pick($urandom_range(9) != 0, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_picks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d pick beats (%0d granted, %0d without a slot) over %0d weight loads.",
                 beats_sent, granted_cnt, denied_cnt, weight_loads);
        $display("Ran free flowing, sender gaps, receiver stalls, both, and a long output hold-off.");
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
